@@ src/mandelbrot_escape_time_pixel_macros.svh @@
// Assertion helpers shared by the block; clk and rst must be in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication.
`define MBET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mbet_pkg.sv @@
package mbet_pkg;

  localparam int FRAC_BITS_DEF = 28;

  localparam int PIX_W      = 14;
  localparam int DIM_W      = 15;
  localparam int LIMIT_W    = 16;
  localparam int OUT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 64;
  localparam int SCALE_W    = LIMIT_W + 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 15'd9200;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 15'd9200;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL_DIV,
    ST_ROW_DIV,
    ST_MUL,
    ST_UPD,
    ST_SCALE_DIV
  } state_t;

  typedef enum logic [1:0] {
    SEL_COL,
    SEL_ROW,
    SEL_SCALE
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_cr;
    logic     set_ci;
    logic     mul;
    logic     update;
    logic     emit_zero;
    logic     emit_quot;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_limit;
    logic escaped;
    logic scale_ok;
  } status_t;

  // Clamp a 64-bit signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-WORD_W:0] top;
    top = v[PROD_W-1:WORD_W-1];
    if (top == '0 || top == '1) begin
      return v[WORD_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ src/mandelbrot_escape_time_pixel.sv @@
// An accepted beat runs the column and row mapping divides, then the multiply/update loop; a point
// that escapes below the limit ends with a scaling divide (none when n reaches the limit or the limit
// is below 2); all divides share the one-bit-per-cycle divider.
// The block takes one pixel at a time; busy is high until the result and a new beat may be taken
// in the cycle done is high. The receiver cannot stall, so the result is never held off.
// Reset (rst, synchronous) returns the controller to idle and loads width/height 9200, limit 500.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [mbet_pkg::PIX_W-1:0]         pixel_col,
  input  logic [mbet_pkg::PIX_W-1:0]         pixel_row,
  output logic                               done,
  output logic [mbet_pkg::OUT_W-1:0]         intensity,
  input  logic                               cfg_we,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [mbet_pkg::DIM_W-1:0]   image_width;
  logic [mbet_pkg::DIM_W-1:0]   image_height;
  logic [mbet_pkg::LIMIT_W-1:0] iteration_limit;
  mbet_pkg::cmd_t               cmd;
  mbet_pkg::status_t            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= mbet_pkg::WIDTH_RST;
      image_height    <= mbet_pkg::HEIGHT_RST;
      iteration_limit <= mbet_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbet_pkg::REG_WIDTH:  image_width     <= cfg_data[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_HEIGHT: image_height    <= cfg_data[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_LIMIT:  iteration_limit <= cfg_data[mbet_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  mbet_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mbet_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .image_width     (image_width),
    .image_height    (image_height),
    .iteration_limit (iteration_limit),
    .intensity       (intensity),
    .done            (done)
  );

endmodule

@@ src/mbet_div.sv @@
module mbet_div #(
  parameter int DW = 42,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = trial - {1'b0, dvs};
    fits  = !diff[VW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ src/mbet_dp.sv @@
module mbet_dp #(
  parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mbet_pkg::cmd_t                  cmd,
  output mbet_pkg::status_t               status,
  input  logic [mbet_pkg::PIX_W-1:0]      pixel_col,
  input  logic [mbet_pkg::PIX_W-1:0]      pixel_row,
  input  logic [mbet_pkg::DIM_W-1:0]      image_width,
  input  logic [mbet_pkg::DIM_W-1:0]      image_height,
  input  logic [mbet_pkg::LIMIT_W-1:0]    iteration_limit,
  output logic [mbet_pkg::OUT_W-1:0]      intensity,
  output logic                            done
);

  localparam int DW  = mbet_pkg::PIX_W + FRAC_BITS;
  localparam int VW  = mbet_pkg::LIMIT_W;
  localparam int PW  = mbet_pkg::PROD_W;
  localparam int WW  = mbet_pkg::WORD_W;

  localparam logic signed [PW-1:0] OFS_RE = 64'sd3 <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] OFS_IM = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [PW-1:0]        BOUND  = 64'd4 << (2 * FRAC_BITS);

  logic [mbet_pkg::PIX_W-1:0]   row_q;
  logic signed [WW-1:0]         cr;
  logic signed [WW-1:0]         ci;
  logic signed [WW-1:0]         zr;
  logic signed [WW-1:0]         zi;
  logic signed [PW-1:0]         zr2;
  logic signed [PW-1:0]         zi2;
  logic signed [PW-1:0]         zri;
  logic [mbet_pkg::LIMIT_W-1:0] count;

  logic [DW-1:0]                div_dividend;
  logic [VW-1:0]                div_divisor;
  logic [DW-1:0]                div_quot;
  logic                         div_done;
  logic [mbet_pkg::SCALE_W-1:0] scaled;
  logic [mbet_pkg::DIM_W-1:0]   width_eff;
  logic [mbet_pkg::DIM_W-1:0]   height_eff;
  logic signed [PW-1:0]         map_re;
  logic signed [PW-1:0]         map_im;
  logic [PW-1:0]                mag;
  logic signed [PW-1:0]         nr_full;
  logic signed [PW-1:0]         ni_full;

  always_comb begin
    width_eff  = (image_width == '0) ? mbet_pkg::DIM_W'(1) : image_width;
    height_eff = (image_height == '0) ? mbet_pkg::DIM_W'(1) : image_height;
    // 255 * count
    scaled = {count, 8'd0} - {8'd0, count};
    case (cmd.div_sel)
      mbet_pkg::SEL_COL: begin
        div_dividend = {pixel_col, {FRAC_BITS{1'b0}}};
        div_divisor  = VW'(width_eff);
      end
      mbet_pkg::SEL_ROW: begin
        div_dividend = {row_q, {FRAC_BITS{1'b0}}};
        div_divisor  = VW'(height_eff);
      end
      mbet_pkg::SEL_SCALE: begin
        div_dividend = DW'(scaled);
        div_divisor  = iteration_limit - VW'(1);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = VW'(1);
      end
    endcase
  end

  mbet_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_comb begin
    map_re  = $signed(PW'(div_quot)) - OFS_RE;
    map_im  = $signed(PW'(div_quot)) - OFS_IM;
    mag     = $unsigned(zr2) + $unsigned(zi2);
    nr_full = ((zr2 - zi2) >>> FRAC_BITS) + PW'(cr);
    ni_full = (zri >>> (FRAC_BITS - 1)) + PW'(ci);
  end

  always_comb begin
    status.div_done = div_done;
    status.at_limit = count >= iteration_limit;
    status.escaped  = mag >= BOUND;
    status.scale_ok = (count < iteration_limit) && (iteration_limit > VW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q <= pixel_row;
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.update) begin
      zr    <= mbet_pkg::sat_word(nr_full);
      zi    <= mbet_pkg::sat_word(ni_full);
      count <= count + mbet_pkg::LIMIT_W'(1);
    end
    if (cmd.set_cr) begin
      cr <= mbet_pkg::sat_word(map_re);
    end
    if (cmd.set_ci) begin
      ci <= mbet_pkg::sat_word(map_im);
    end
    // Register products before the escape test and update.
    if (cmd.mul) begin
      zr2 <= zr * zr;
      zi2 <= zi * zi;
      zri <= zr * zi;
    end
    if (cmd.emit_quot) begin
      intensity <= div_quot[mbet_pkg::OUT_W-1:0];
    end else if (cmd.emit_zero) begin
      intensity <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_quot || cmd.emit_zero;
    end
  end

endmodule

@@ src/mbet_ctrl.sv @@
`include "mandelbrot_escape_time_pixel_macros.svh"

module mbet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mbet_pkg::status_t status,
  output mbet_pkg::cmd_t    cmd
);

  mbet_pkg::state_t state;
  mbet_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mbet_pkg::ST_IDLE: begin
        if (start) state_next = mbet_pkg::ST_COL_DIV;
      end
      mbet_pkg::ST_COL_DIV: begin
        if (status.div_done) state_next = mbet_pkg::ST_ROW_DIV;
      end
      mbet_pkg::ST_ROW_DIV: begin
        if (status.div_done) state_next = mbet_pkg::ST_MUL;
      end
      mbet_pkg::ST_MUL: begin
        if (!status.at_limit) begin
          state_next = mbet_pkg::ST_UPD;
        end else if (status.scale_ok) begin
          state_next = mbet_pkg::ST_SCALE_DIV;
        end else begin
          state_next = mbet_pkg::ST_IDLE;
        end
      end
      mbet_pkg::ST_UPD: begin
        if (!status.escaped) begin
          state_next = mbet_pkg::ST_MUL;
        end else if (status.scale_ok) begin
          state_next = mbet_pkg::ST_SCALE_DIV;
        end else begin
          state_next = mbet_pkg::ST_IDLE;
        end
      end
      mbet_pkg::ST_SCALE_DIV: begin
        if (status.div_done) state_next = mbet_pkg::ST_IDLE;
      end
      default: state_next = mbet_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = mbet_pkg::SEL_COL;
    busy        = state != mbet_pkg::ST_IDLE;
    case (state)
      mbet_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      mbet_pkg::ST_COL_DIV: begin
        if (status.div_done) begin
          cmd.set_cr    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = mbet_pkg::SEL_ROW;
        end
      end
      mbet_pkg::ST_ROW_DIV: begin
        cmd.div_sel = mbet_pkg::SEL_ROW;
        if (status.div_done) cmd.set_ci = 1'b1;
      end
      mbet_pkg::ST_MUL: begin
        cmd.div_sel = mbet_pkg::SEL_SCALE;
        if (!status.at_limit) begin
          cmd.mul = 1'b1;
        end else if (status.scale_ok) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.emit_zero = 1'b1;
        end
      end
      mbet_pkg::ST_UPD: begin
        cmd.div_sel = mbet_pkg::SEL_SCALE;
        if (!status.escaped) begin
          cmd.update = 1'b1;
        end else if (status.scale_ok) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.emit_zero = 1'b1;
        end
      end
      mbet_pkg::ST_SCALE_DIV: begin
        cmd.div_sel = mbet_pkg::SEL_SCALE;
        if (status.div_done) cmd.emit_quot = 1'b1;
      end
      default: ;
    endcase
  end

  `MBET_ASSERT_NXT(a_accept_starts_map, start && state == mbet_pkg::ST_IDLE,
                   state == mbet_pkg::ST_COL_DIV, "accepted beat did not start mapping")
  `MBET_ASSERT_IMP(a_upd_after_mul, state == mbet_pkg::ST_UPD,
                   $past(state) == mbet_pkg::ST_MUL, "update step not preceded by multiply")
  `MBET_ASSERT_NXT(a_emit_returns_idle, cmd.emit_zero || cmd.emit_quot,
                   state == mbet_pkg::ST_IDLE, "result emitted but controller not idle")
  `MBET_ASSERT_IMP(a_update_below_limit, cmd.update, !status.at_limit,
                   "iteration past the limit")

endmodule
